// ===== hdl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// shared types and constants of the streaming cosine similarity engine
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int ELEM_BITS = 16;
  localparam int ACC_BITS  = 42;
  localparam int OUT_FRAC  = 15;
  localparam int PROD_BITS = 2 * ELEM_BITS;
  // wide words of the square-root search
  localparam int WIDE_BITS = 120;
  localparam int MUL_CNT_BITS = 6;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic                        last;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] similarity;
    logic                        zero_denominator;
  } out_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] dot;
    logic        [ACC_BITS-1:0] norm_a;
    logic        [ACC_BITS-1:0] norm_b;
  } acc_t;

endpackage

`default_nettype wire

// ===== hdl/cse_fifo.sv =====
// ----------------------------------------------------------------------------
// cse_fifo
// two-entry queue of finished accumulator sets between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cse_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire cse_pkg::acc_t wdata,
  output logic              q_full,
  input  wire logic         rd,
  output cse_pkg::acc_t     rdata,
  output logic              q_empty
);
  import cse_pkg::*;

  acc_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wptr <= ~wptr;
      end
      if (rd && !q_empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr && !q_full) - 2'(rd && !q_empty);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// product stage and saturating accumulators, one element pair per cycle unless a full queue stalls
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cse_pkg::in_t  item,
  output logic               full,
  output logic               q_wr,
  output cse_pkg::acc_t      q_wdata,
  input  wire logic          q_full
);
  import cse_pkg::*;

  logic                        p_valid;
  logic                        p_last;
  logic signed [PROD_BITS-1:0] p_dot;
  logic        [PROD_BITS-1:0] p_na;
  logic        [PROD_BITS-1:0] p_nb;

  logic signed [ACC_BITS-1:0]  dot;
  logic        [ACC_BITS-1:0]  norm_a;
  logic        [ACC_BITS-1:0]  norm_b;

  logic                        stall;
  logic                        accepted;
  logic signed [ACC_BITS:0]    dsum;
  logic        [ACC_BITS:0]    asum;
  logic        [ACC_BITS:0]    bsum;
  acc_t                        sat;

  assign stall    = p_valid && p_last && q_full;
  assign full     = stall;
  assign accepted = push && !stall;

  always_comb begin
    dsum = {dot[ACC_BITS-1], dot} + (ACC_BITS+1)'(p_dot);
    asum = {1'b0, norm_a} + (ACC_BITS+1)'(p_na);
    bsum = {1'b0, norm_b} + (ACC_BITS+1)'(p_nb);
    // clamp to the accumulator range instead of wrapping
    if (dsum[ACC_BITS] != dsum[ACC_BITS-1]) begin
      sat.dot = dsum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat.dot = dsum[ACC_BITS-1:0];
    end
    sat.norm_a = asum[ACC_BITS] ? {ACC_BITS{1'b1}} : asum[ACC_BITS-1:0];
    sat.norm_b = bsum[ACC_BITS] ? {ACC_BITS{1'b1}} : bsum[ACC_BITS-1:0];
  end

  assign q_wr    = p_valid && p_last && !q_full;
  assign q_wdata = sat;

  always_ff @(posedge clk) begin
    if (!stall) begin
      p_last <= item.last;
      p_dot  <= item.elem_a * item.elem_b;
      p_na   <= PROD_BITS'(item.elem_a * item.elem_a);
      p_nb   <= PROD_BITS'(item.elem_b * item.elem_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      dot     <= '0;
      norm_a  <= '0;
      norm_b  <= '0;
    end else if (!stall) begin
      p_valid <= accepted;
      if (p_valid) begin
        if (p_last) begin
          dot    <= '0;
          norm_a <= '0;
          norm_b <= '0;
        end else begin
          dot    <= sat.dot;
          norm_a <= sat.norm_a;
          norm_b <= sat.norm_b;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// shift-add products, bit-serial square-root search and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cse_pkg::acc_t q_rdata,
  input  wire logic          q_empty,
  output logic               q_rd,
  output cse_pkg::out_t      result,
  output logic               empty,
  input  wire logic          pop
);
  import cse_pkg::*;

  typedef enum logic [2:0] {IDLE, MUL, PREP, ROOT, DONE} state_t;

  state_t                  state;
  logic                    neg;
  logic                    zero;
  logic [2*ACC_BITS-1:0]   mc_p;
  logic [ACC_BITS-1:0]     mp_p;
  logic [2*ACC_BITS-1:0]   acc_p;
  logic [2*ACC_BITS-1:0]   mc_d;
  logic [ACC_BITS-1:0]     mp_d;
  logic [2*ACC_BITS-1:0]   acc_d;
  logic [MUL_CNT_BITS-1:0] mcnt;
  logic [WIDE_BITS-1:0]    rhs;
  logic [WIDE_BITS-1:0]    s_acc;
  logic [WIDE_BITS-1:0]    v_acc;
  logic [WIDE_BITS-1:0]    u_acc;
  logic [3:0]              bitk;
  logic [OUT_FRAC:0]       q;
  logic                    out_valid;

  logic [WIDE_BITS-1:0]    cand;
  logic                    fits;
  logic [ACC_BITS-1:0]     mag;
  logic                    out_free;
  logic [ELEM_BITS-1:0]    sim;

  assign mag      = q_rdata.dot[ACC_BITS-1] ? ACC_BITS'(-q_rdata.dot) : ACC_BITS'(q_rdata.dot);
  assign cand     = s_acc + v_acc + u_acc;
  assign fits     = (cand <= rhs);
  assign out_free = !out_valid || pop;
  assign q_rd     = (state == IDLE) && !q_empty;
  assign empty    = !out_valid;

  always_comb begin
    if (zero) begin
      sim = '0;
    end else if (neg) begin
      sim = ELEM_BITS'(-q);
    end else if (q[OUT_FRAC]) begin
      sim = {1'b0, {(ELEM_BITS-1){1'b1}}};
    end else begin
      sim = ELEM_BITS'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == DONE) && out_free) || (out_valid && !pop);
      case (state)
        IDLE: begin
          if (!q_empty) begin
            neg   <= q_rdata.dot[ACC_BITS-1];
            zero  <= (q_rdata.norm_a == '0) || (q_rdata.norm_b == '0);
            mc_p  <= (2*ACC_BITS)'(q_rdata.norm_a);
            mp_p  <= q_rdata.norm_b;
            acc_p <= '0;
            mc_d  <= (2*ACC_BITS)'(mag);
            mp_d  <= mag;
            acc_d <= '0;
            mcnt  <= '0;
            q     <= '0;
            state <= ((q_rdata.norm_a == '0) || (q_rdata.norm_b == '0)) ? DONE : MUL;
          end
        end
        MUL: begin
          if (mp_p[0]) acc_p <= acc_p + mc_p;
          if (mp_d[0]) acc_d <= acc_d + mc_d;
          mc_p <= mc_p << 1;
          mp_p <= mp_p >> 1;
          mc_d <= mc_d << 1;
          mp_d <= mp_d >> 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MUL_CNT_BITS'(ACC_BITS - 1)) begin
            state <= PREP;
          end
        end
        PREP: begin
          rhs   <= WIDE_BITS'(acc_d) << (2 * OUT_FRAC);
          u_acc <= WIDE_BITS'(acc_p) << (2 * OUT_FRAC);
          s_acc <= '0;
          v_acc <= '0;
          bitk  <= 4'(OUT_FRAC);
          state <= ROOT;
        end
        ROOT: begin
          // candidate = (q + 2^k)^2 * P, kept as s + v + u with v = q*P<<(k+1), u = P<<2k
          if (fits) begin
            s_acc   <= cand;
            q[bitk] <= 1'b1;
          end
          v_acc <= (v_acc >> 1) + (fits ? u_acc : '0);
          u_acc <= u_acc >> 2;
          bitk  <= bitk - 1'b1;
          // full scale reached: no lower bit may be added
          if ((bitk == 4'(OUT_FRAC) && fits) || bitk == '0) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            result.similarity       <= sim;
            result.zero_denominator <= zero;
            state                   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_zero_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.zero_denominator |-> result.similarity == '0)
    else $error("zero denominator with nonzero similarity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("waiting result overwritten");

  a_root_bits: assert property (@(posedge clk) disable iff (rst)
    state == ROOT && q[OUT_FRAC] |-> q[OUT_FRAC-1:0] == '0)
    else $error("root exceeded full scale");

endmodule

`default_nettype wire

// ===== hdl/cosine_similarity_engine_unit.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine_unit
// streaming cosine similarity of two Q1.15 vectors given as element pairs
// ----------------------------------------------------------------------------
// input queue side: push an element pair while full is low; last marks the
// final pair of a vector. one pair is taken every cycle while full is low.
// result queue side: while empty is low, result holds the oldest similarity
// (Q1.15, truncated, saturated) and its zero_denominator flag; pop takes it.
// only the transaction flagged last yields a result.
// from the last pair to the result the data passes the product register,
// the queue, the shift-add products in the back unit, the bit-serial
// square-root search and the output register.
// a zero norm skips the shift-add products and the search.
// a two-entry queue holds finished accumulator sets, so the next vector
// streams in while the back unit works; back-to-back short vectors that
// arrive faster than the back unit finishes them eventually raise full.
// a result that is not popped holds the back unit, then the queue, then full.
// reset (rst, synchronous) clears the accumulators and empties all queues.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_engine_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cse_pkg::in_t  item,
  output logic               full,
  input  wire logic          pop,
  output cse_pkg::out_t      result,
  output logic               empty
);
  import cse_pkg::*;

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  acc_t q_wdata;
  acc_t q_rdata;

  cse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  cse_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  cse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_cosine_similarity_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cosine_similarity_engine_unit
// pushes element pairs into the engine and checks each similarity result
// against a predictor that uses exact integer arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cosine_similarity_engine_unit;
  import cse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  // expected similarity results in order, with the accumulator state
  class similarity_scoreboard;
    out_t pending[$];
    logic signed [63:0] dot;
    logic [63:0] norm_a;
    logic [63:0] norm_b;
    int fails;

    function new();
      dot = 0;
      norm_a = 0;
      norm_b = 0;
      fails = 0;
    endfunction

    function void note_pair(in_t it);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] dmax;
      logic [63:0] nmax;
      logic [127:0] prod;
      logic [127:0] rhs;
      logic [63:0] mag;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      out_t r;
      a = it.elem_a;
      b = it.elem_b;
      dmax = (64'sd1 <<< 41) - 1;
      nmax = (64'd1 << 42) - 1;
      dot = dot + a * b;
      if (dot > dmax) dot = dmax;
      if (dot < -dmax - 1) dot = -dmax - 1;
      norm_a = norm_a + 64'(a * a);
      if (norm_a > nmax) norm_a = nmax;
      norm_b = norm_b + 64'(b * b);
      if (norm_b > nmax) norm_b = nmax;
      if (!it.last) return;
      r.similarity = '0;
      r.zero_denominator = 1'b0;
      if (norm_a == 0 || norm_b == 0) begin
        r.zero_denominator = 1'b1;
      end else begin
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        prod = 128'(norm_a) * 128'(norm_b);
        rhs = (128'(mag) * 128'(mag)) << 30;
        lo = 0;
        hi = 64'd32768;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (prod * 128'(mid * mid) <= rhs) lo = mid;
          else hi = mid - 1;
        end
        if (dot < 0) r.similarity = 16'(-lo);
        else r.similarity = (lo > 32767) ? 16'sd32767 : 16'(lo);
      end
      pending.insert(pending.size(), r);
      dot = 0;
      norm_a = 0;
      norm_b = 0;
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result similarity=%0d zero_denominator=%0b",
               got.similarity, got.zero_denominator);
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.similarity !== exp_r.similarity) begin
        $error("similarity expected %0d actual %0d", exp_r.similarity, got.similarity);
        fails++;
      end
      if (got.zero_denominator !== exp_r.zero_denominator) begin
        $error("zero_denominator expected %0b actual %0b",
               exp_r.zero_denominator, got.zero_denominator);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  in_t  item;
  logic full;
  logic pop;
  out_t result;
  logic empty;

  similarity_scoreboard sb;
  in_t  pairs[$];
  int   idle_cycles;
  bit   stall_pattern;

  cosine_similarity_engine_unit DUT (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void enqueue_pair(in_t p);
    pairs.insert(pairs.size(), p);
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t make_pair(logic [15:0] a, logic [15:0] b, logic l);
    in_t p;
    p.elem_a = a;
    p.elem_b = b;
    p.last = l;
    return p;
  endfunction

  task automatic queue_vector(int len, int kind);
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i < len; i++) begin
      a = rand_elem();
      b = rand_elem();
      case (kind)
        1: b = a;
        2: b = 16'(-$signed(a));
        3: a = 16'h0000;
        default: ;
      endcase
      enqueue_pair(make_pair(a, b, i == len - 1));
    end
  endtask

  // sender: bursts with random gaps
  task automatic send_pairs();
    int burst;
    int gap;
    burst = 0;
    while (pairs.size() > 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      push <= 1'b1;
      item <= pairs[0];
      @(posedge clk);
      if (!full) begin
        sb.note_pair(pairs.pop_front());
        burst--;
      end
    end
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() > 0) @(posedge clk);
  endtask

  // receiver: stalls in phases, sometimes none
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(result);
      if ($urandom_range(0, 63) == 0) stall_pattern <= ~stall_pattern;
      pop <= stall_pattern ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    item = '0;
    stall_pattern = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, zero norms, single elements, saturation
    enqueue_pair(make_pair(16'h7fff, 16'h7fff, 1'b1));
    enqueue_pair(make_pair(16'h8000, 16'h8000, 1'b1));
    enqueue_pair(make_pair(16'h8000, 16'h7fff, 1'b1));
    enqueue_pair(make_pair(16'h7fff, 16'h8000, 1'b1));
    enqueue_pair(make_pair(16'h0000, 16'h1234, 1'b1));
    enqueue_pair(make_pair(16'h4321, 16'h0000, 1'b1));
    enqueue_pair(make_pair(16'h0000, 16'h0000, 1'b1));
    enqueue_pair(make_pair(16'h0001, 16'hffff, 1'b1));
    enqueue_pair(make_pair(16'h0001, 16'h0000, 1'b0));
    enqueue_pair(make_pair(16'h0000, 16'h0001, 1'b1));
    enqueue_pair(make_pair(16'h3000, 16'h4000, 1'b0));
    enqueue_pair(make_pair(16'hc000, 16'h3000, 1'b1));
    enqueue_pair(make_pair(16'h5555, 16'haaaa, 1'b1));
    send_pairs();
    // hold off until every result has come
    wait_drained();
    // long vectors of extreme elements
    for (int i = 0; i < 60; i++)
      enqueue_pair(make_pair(16'h8000, 16'h8000, i == 59));
    for (int i = 0; i < 60; i++)
      enqueue_pair(make_pair(16'h8000, 16'h7fff, i == 59));
    send_pairs();
    wait_drained();
    // random vectors, mostly short
    for (int n = 0; n < 520; ) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      queue_vector(len, $urandom_range(0, 5));
      n += len;
    end
    send_pairs();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== cosine_similarity_engine_unit.f =====
hdl/cse_pkg.sv
hdl/cse_fifo.sv
hdl/cse_front.sv
hdl/cse_back.sv
hdl/cosine_similarity_engine_unit.sv
tb/sv/tb_cosine_similarity_engine_unit.sv
